// ===== rtl/core/irpw_pkg.sv =====
// ----------------------------------------------------------------------------
// irpw_pkg
// Types, codes and helpers shared by the IR pulse-width frame sender.
// ----------------------------------------------------------------------------
package irpw_pkg;

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned FIELD_W = 5;
    localparam int unsigned FRAME_W = 16;
    localparam int unsigned CHUNK_W = 20;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // operation codes
    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_SINGLE = 2'd1;
    localparam logic [1:0] OP_TIME   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_LONG  = 2'd0;
    localparam logic [1:0] REG_SHORT = 2'd1;
    localparam logic [1:0] REG_GAP   = 2'd2;
    localparam logic [1:0] REG_CODE  = 2'd3;

    localparam logic [TICK_W-1:0]  LONG_RESET  = 16'd1600;
    localparam logic [TICK_W-1:0]  SHORT_RESET = 16'd800;
    localparam logic [TICK_W-1:0]  GAP_RESET   = 16'd3000;
    localparam logic [FIELD_W-1:0] CODE_RESET  = 5'd2;

    localparam logic [2:0] FRAMES_TIME = 3'd5;
    localparam logic [2:0] FRAMES_REPEAT_LIMIT = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_MARK  = 2'd1,
        PH_SPACE = 2'd2,
        PH_GAP   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  player;
        logic [4:0]  payload;
        logic        repeat_frame;
        logic [9:0]  game_time;
        logic [7:0]  countdown;
    } t_in_item;

    typedef struct packed {
        logic led_on;
        logic busy_res;
        logic dropped;
    } t_out_item;

    typedef struct packed {
        logic [TICK_W-1:0]  long_ticks;
        logic [TICK_W-1:0]  short_ticks;
        logic [TICK_W-1:0]  gap_ticks;
        logic [FIELD_W-1:0] message_code;
    } t_cfg;

    // start bit, player, payload, check field
    function automatic logic [FRAME_W-1:0] build_frame(
        input logic [FIELD_W-1:0] who,
        input logic [FIELD_W-1:0] what
    );
        build_frame = {1'b1, who, what, who ^ what};
    endfunction

endpackage

// ===== rtl/core/irpw_engine.sv =====
// ----------------------------------------------------------------------------
// irpw_engine
// Frame sequencer: holds transfer state; advances one item a cycle on i_step.
// ----------------------------------------------------------------------------
module irpw_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  irpw_pkg::t_cfg      i_cfg,
    input  logic                i_step,
    input  irpw_pkg::t_in_item  i_item,
    output irpw_pkg::t_out_item o_res
);

    irpw_pkg::t_phase r_phase, n_phase;
    logic [irpw_pkg::FRAME_W-1:0] r_frame, n_frame;
    logic [3:0]                   r_bit_idx, n_bit_idx;
    logic [irpw_pkg::TICK_W-1:0]  r_cnt, n_cnt;
    logic [irpw_pkg::CHUNK_W-1:0] r_chunks, n_chunks;
    logic [2:0]                   r_frames_left, n_frames_left;
    logic [irpw_pkg::FIELD_W-1:0] r_player, n_player;

    logic                         is_cmd;
    logic                         cur_bit;
    logic [irpw_pkg::TICK_W-1:0]  cnt_inc;

    assign is_cmd  = (i_item.operation == irpw_pkg::OP_SINGLE) ||
                     (i_item.operation == irpw_pkg::OP_TIME);
    assign cur_bit = r_frame[r_bit_idx];
    assign cnt_inc = r_cnt + 16'd1;

    always_comb begin
        n_phase       = r_phase;
        n_frame       = r_frame;
        n_bit_idx     = r_bit_idx;
        n_cnt         = r_cnt;
        n_chunks      = r_chunks;
        n_frames_left = r_frames_left;
        n_player      = r_player;
        if (i_step) begin
            if (is_cmd) begin
                if (r_phase == irpw_pkg::PH_IDLE) begin
                    n_player  = i_item.player;
                    n_bit_idx = 4'd15;
                    n_cnt     = '0;
                    n_phase   = irpw_pkg::PH_MARK;
                    if (i_item.operation == irpw_pkg::OP_SINGLE) begin
                        n_chunks      = {i_item.payload, 15'd0};
                        n_frames_left = {2'b00, i_item.repeat_frame};
                        n_frame = irpw_pkg::build_frame(i_item.player, i_item.payload);
                    end else begin
                        // time high, time low, countdown high, countdown low
                        n_chunks      = {i_item.game_time, 2'b00,
                                         i_item.countdown};
                        n_frames_left = irpw_pkg::FRAMES_TIME;
                        n_frame = irpw_pkg::build_frame(i_item.player,
                                                        i_cfg.message_code);
                    end
                end
            end else if (r_phase != irpw_pkg::PH_IDLE) begin
                n_cnt = cnt_inc;
                case (r_phase)
                    irpw_pkg::PH_MARK: begin
                        if (cnt_inc >= (cur_bit ? i_cfg.long_ticks : i_cfg.short_ticks)) begin
                            n_cnt   = '0;
                            n_phase = irpw_pkg::PH_SPACE;
                        end
                    end
                    irpw_pkg::PH_SPACE: begin
                        if (cnt_inc >= (cur_bit ? i_cfg.short_ticks : i_cfg.long_ticks)) begin
                            n_cnt = '0;
                            if (r_bit_idx == 4'd0) begin
                                n_phase = (r_frames_left != 3'd0) ? irpw_pkg::PH_GAP
                                                                  : irpw_pkg::PH_IDLE;
                            end else begin
                                n_bit_idx = r_bit_idx - 4'd1;
                                n_phase   = irpw_pkg::PH_MARK;
                            end
                        end
                    end
                    irpw_pkg::PH_GAP: begin
                        if (cnt_inc >= i_cfg.gap_ticks) begin
                            // beyond the chunk count the same frame goes again
                            if (r_frames_left <= irpw_pkg::FRAMES_REPEAT_LIMIT) begin
                                n_frame  = irpw_pkg::build_frame(r_player,
                                               r_chunks[irpw_pkg::CHUNK_W-1 -: 5]);
                                n_chunks = {r_chunks[irpw_pkg::CHUNK_W-6:0], 5'd0};
                            end
                            n_frames_left = r_frames_left - 3'd1;
                            n_bit_idx     = 4'd15;
                            n_cnt         = '0;
                            n_phase       = irpw_pkg::PH_MARK;
                        end
                    end
                    default: begin
                        n_cnt = '0;
                    end
                endcase
            end
        end
    end

    // a command reports the state it leaves, a tick the state it ran in
    always_comb begin
        if (is_cmd) begin
            o_res.led_on   = (n_phase == irpw_pkg::PH_MARK);
            o_res.busy_res = (n_phase != irpw_pkg::PH_IDLE);
            o_res.dropped  = (r_phase != irpw_pkg::PH_IDLE);
        end else begin
            o_res.led_on   = (r_phase == irpw_pkg::PH_MARK);
            o_res.busy_res = (r_phase != irpw_pkg::PH_IDLE);
            o_res.dropped  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= irpw_pkg::PH_IDLE;
            r_frame       <= '0;
            r_bit_idx     <= '0;
            r_cnt         <= '0;
            r_chunks      <= '0;
            r_frames_left <= '0;
            r_player      <= '0;
        end else begin
            r_phase       <= n_phase;
            r_frame       <= n_frame;
            r_bit_idx     <= n_bit_idx;
            r_cnt         <= n_cnt;
            r_chunks      <= n_chunks;
            r_frames_left <= n_frames_left;
            r_player      <= n_player;
        end
    end

endmodule

// ===== rtl/core/ir_pulse_width_frame_sender.sv =====
// ----------------------------------------------------------------------------
// ir_pulse_width_frame_sender
// IR pulse-width frame sender with APB timing registers and a skid output.
// ----------------------------------------------------------------------------
// One item is taken every clock while not stalled and gives one registered
// result. Tick items time the marks, spaces and gaps of the frame being sent;
// send commands start a single frame or a six-frame time message and are
// dropped when a transfer is already running. The output side has a result
// register and a one-entry skid register, so the input keeps being taken
// while one result waits; input stall rises only when both are full.
// ----------------------------------------------------------------------------
module ir_pulse_width_frame_sender (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  irpw_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output irpw_pkg::t_out_item            o_out_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [irpw_pkg::ADDR_W-1:0]    paddr,
    input  logic [irpw_pkg::DATA_W-1:0]    pwdata,
    output logic [irpw_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    irpw_pkg::t_cfg      r_cfg;
    irpw_pkg::t_out_item res;
    irpw_pkg::t_out_item r_out_item, r_skid_item;
    logic                r_out_valid, r_skid_valid;
    logic                in_accept, out_take, cfg_write;
    logic [1:0]          reg_idx;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_ticks   <= irpw_pkg::LONG_RESET;
            r_cfg.short_ticks  <= irpw_pkg::SHORT_RESET;
            r_cfg.gap_ticks    <= irpw_pkg::GAP_RESET;
            r_cfg.message_code <= irpw_pkg::CODE_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                irpw_pkg::REG_LONG:  r_cfg.long_ticks   <= pwdata[15:0];
                irpw_pkg::REG_SHORT: r_cfg.short_ticks  <= pwdata[15:0];
                irpw_pkg::REG_GAP:   r_cfg.gap_ticks    <= pwdata[15:0];
                irpw_pkg::REG_CODE:  r_cfg.message_code <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            irpw_pkg::REG_LONG:  prdata = {16'd0, r_cfg.long_ticks};
            irpw_pkg::REG_SHORT: prdata = {16'd0, r_cfg.short_ticks};
            irpw_pkg::REG_GAP:   prdata = {16'd0, r_cfg.gap_ticks};
            irpw_pkg::REG_CODE:  prdata = {27'd0, r_cfg.message_code};
            default:             prdata = '0;
        endcase
    end

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    irpw_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (in_accept),
        .i_item  (i_in_item),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_take || !r_out_valid) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_accept;
                end
            end else if (in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            r_out_item <= r_skid_valid ? r_skid_item : res;
        end else if (in_accept) begin
            r_skid_item <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // skid entry is only filled behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output entry");

    // a held skid item is kept until the output moves
    a_skid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> r_skid_valid)
        else $error("skid item lost while output stalled");

    // a drop only happens during a transfer
    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.dropped) |-> o_out_item.busy_res)
        else $error("dropped command reported while idle");

    // the led only lights inside a transfer
    a_led_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.led_on) |-> o_out_item.busy_res)
        else $error("led on while not busy");

endmodule
